/* design/positional_list_engine_unit_macros.svh */
// Assertion macros used by the port-level checker of the list engine.
// No dependencies.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define PLEU_ASSERT_RST(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PLEU_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

/* design/pleu_pkg.sv */
// Package of the positional list engine: field widths, operation codes,
// shift control type. No dependencies.
`timescale 1ns / 1ps

package pleu_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int OP_W   = 2;
  localparam int LEN_W  = 5;
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2
  } shift_mode_t;

  typedef struct packed {
    shift_mode_t      mode;
    logic [POS_W-1:0] pos;
  } shift_ctl_t;

endpackage

/* design/pleu_cell.sv */
// One storage cell of the list chain: holds one entry and loads the new value
// or its lower or upper neighbor on a shift. Depends on pleu_pkg.
`timescale 1ns / 1ps

module pleu_cell #(
  parameter int INDEX = 0
) (
  input  logic                       clk,
  input  pleu_pkg::shift_ctl_t       ctl,
  input  logic [pleu_pkg::DATA_W-1:0] ins,
  input  logic [pleu_pkg::DATA_W-1:0] lower,
  input  logic [pleu_pkg::DATA_W-1:0] upper,
  output logic [pleu_pkg::DATA_W-1:0] q
);
  import pleu_pkg::*;

  logic at_pos;
  logic above_pos;

  assign at_pos    = (INDEX == int'(ctl.pos));
  assign above_pos = (INDEX > int'(ctl.pos));

  always_ff @(posedge clk) begin
    case (ctl.mode)
      MODE_INSERT: begin
        if (above_pos) begin
          q <= lower;
        end else if (at_pos) begin
          q <= ins;
        end
      end
      MODE_REMOVE: begin
        if (above_pos || at_pos) begin
          q <= upper;
        end
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

/* design/positional_list_engine_unit.sv */
// Top level of the positional list engine: list control, cell chain and
// result register. Depends on pleu_pkg and pleu_cell.
// Usage:
//   Requests enter on the s_ channel: s_tuser carries the operation
//   (insert, remove, read, clear), s_tdata the position and the value.
//   Each request yields exactly one result on the m_ channel carrying
//   ok, read_value, length and full_res.
//   Entries sit in a chain of cells; an insert or remove shifts the cells
//   from the position upward together, on the edge that takes the request.
//   Latency: the result is valid the cycle after the request is taken.
//   Throughput: one request per cycle while the receiver takes the results.
//   The result register frees up while it is being taken, so s_tready stays
//   high as long as m_tready is high or no result is pending.
//   When the receiver stalls, the result holds and s_tready drops until it
//   is taken.
//   Reset empties the list (length 0) and drops any pending result; entry
//   contents are not cleared and are never read before being written.
//   Reads reach positions below 32 only, as the position field is 5 bits.
`timescale 1ns / 1ps

module positional_list_engine_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [4:0] position, [36:5] value, [39:37] zero
  input  logic [pleu_pkg::S_TDATA_W-1:0] s_tdata,
  // [1:0] operation
  input  logic [pleu_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] ok, [32:1] read_value, [37:33] length, [38] full_res, [39] zero
  output logic [pleu_pkg::M_TDATA_W-1:0] m_tdata
);
  import pleu_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int RD = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [XW-1:0]     cnt_ext;
  logic [XW-1:0]     pos_ext;
  logic              accept;
  logic              full_now;
  logic              in_range;
  logic              ins_ok;
  logic              op_ok;
  op_t               op;
  logic [POS_W-1:0]  pos;
  logic [DATA_W-1:0] val;
  logic [DATA_W-1:0] rd_word;
  logic [DATA_W-1:0] rd_value;
  shift_ctl_t        ctl;
  logic [DATA_W-1:0] cells [CAPACITY];
  logic [XW-1:0]     len_ext;

  logic              res_ok;
  logic [DATA_W-1:0] res_value;
  logic [LEN_W-1:0]  res_len;
  logic              res_full;

  assign op  = op_t'(s_tuser[OP_W-1:0]);
  assign pos = s_tdata[POS_W-1:0];
  assign val = s_tdata[POS_W+DATA_W-1:POS_W];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign cnt_ext  = XW'(count);
  assign pos_ext  = XW'(pos);
  assign full_now = (count == CW'(CAPACITY));
  assign in_range = (pos_ext < cnt_ext);
  assign ins_ok   = (pos_ext <= cnt_ext) && !full_now;

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < RD; i++) begin
      if (pos_ext == XW'(i)) begin
        rd_word = cells[i];
      end
    end
  end

  always_comb begin
    op_ok      = 1'b0;
    count_next = count;
    rd_value   = '0;
    ctl.mode   = MODE_HOLD;
    ctl.pos    = pos;
    case (op)
      OP_INSERT: begin
        op_ok = ins_ok;
        if (ins_ok) begin
          count_next = count + CW'(1);
          ctl.mode   = accept ? MODE_INSERT : MODE_HOLD;
        end
      end
      OP_REMOVE: begin
        op_ok = in_range;
        if (in_range) begin
          count_next = count - CW'(1);
          ctl.mode   = accept ? MODE_REMOVE : MODE_HOLD;
        end
      end
      OP_READ: begin
        op_ok = in_range;
        if (in_range) begin
          rd_value = rd_word;
        end
      end
      OP_CLEAR: begin
        op_ok      = 1'b1;
        count_next = '0;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] upper;
    if (i == 0) begin : g_lo
      assign lower = val;
    end else begin : g_lo
      assign lower = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign upper = cells[i];
    end else begin : g_hi
      assign upper = cells[i+1];
    end
    pleu_cell #(
      .INDEX(i)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .ins  (val),
      .lower(lower),
      .upper(upper),
      .q    (cells[i])
    );
  end

  assign len_ext = XW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      m_tvalid <= accept || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_ok    <= op_ok;
      res_value <= rd_value;
      res_len   <= len_ext[LEN_W-1:0];
      res_full  <= (count_next == CW'(CAPACITY));
    end
  end

  assign m_tdata = {1'b0, res_full, res_len, res_value, res_ok};

endmodule

/* design/pleu_checker.sv */
// Port-level checks for the positional list engine, bound to the top level.
// Depends on pleu_pkg and positional_list_engine_unit_macros.svh.
`timescale 1ns / 1ps
`include "positional_list_engine_unit_macros.svh"

module pleu_checker #(
  parameter int CAPACITY = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [pleu_pkg::M_TDATA_W-1:0] m_tdata
);
  import pleu_pkg::*;

  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

  logic              req_taken;
  logic              res_stalled;
  logic              res_ok;
  logic [DATA_W-1:0] res_value;
  logic [LEN_W-1:0]  res_len;
  logic              res_full;

  assign req_taken   = s_tvalid && s_tready;
  assign res_stalled = m_tvalid && !m_tready;
  assign res_ok      = m_tdata[0];
  assign res_value   = m_tdata[32:1];
  assign res_len     = m_tdata[37:33];
  assign res_full    = m_tdata[38];

  `PLEU_ASSERT_ALWAYS(a_reset_drops_result, clk,
    rst |=> !m_tvalid, "result after reset")
  `PLEU_ASSERT_RST(a_request_gives_result, clk, rst,
    req_taken |=> m_tvalid, "no result")
  `PLEU_ASSERT_RST(a_stall_holds, clk, rst,
    res_stalled |=> m_tvalid && $stable(m_tdata), "stalled result changed")
  `PLEU_ASSERT_RST(a_full_length, clk, rst,
    m_tvalid && res_full |-> res_len == CAP_LEN, "full flag with wrong length")
  `PLEU_ASSERT_RST(a_value_needs_ok, clk, rst,
    m_tvalid && (res_value != '0) |-> res_ok, "value without ok")

endmodule

bind positional_list_engine_unit pleu_checker #(
  .CAPACITY(CAPACITY)
) u_pleu_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

/* tb/sv/positional_list_engine_unit_tb.sv */
// Testbench of positional_list_engine_unit: a bounded list driven with insert,
// remove, read and clear requests, each result checked against a local list model.
// Depends on pleu_pkg and the engine RTL.
`timescale 1ns / 1ps

module positional_list_engine_unit_tb;
  import pleu_pkg::*;

  localparam int LIST_CAP   = 16;
  localparam int RAND_ITEMS = 550;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    op_t                      op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } list_req_t;

  typedef struct {
    logic              okay;
    logic [DATA_W-1:0] rd_value;
    logic [LEN_W-1:0]  len;
    logic              full_flag;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  list_req_t    req_q[$];
  list_result_t result_q[$];
  list_req_t    cur_req;
  list_result_t want_r;

  logic [DATA_W-1:0] list_mem [LIST_CAP];
  int list_len;
  int gen_len;
  int n_gen;
  int n_errors;
  int n_results;
  int n_ok;
  int n_full;
  int n_op [4];
  int burst_left;
  int gap_left;
  int rx_left;
  int rx_mode;
  int idle_cycles;
  int cyc;

  positional_list_engine_unit #(.CAPACITY(LIST_CAP)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  // list model: works out the result of one accepted request
  task automatic apply_req(input list_req_t r);
    list_result_t res;
    int i;
    res = '{okay: 1'b0, rd_value: '0, len: '0, full_flag: 1'b0};
    case (r.op)
      OP_INSERT: begin
        if (r.pos <= list_len && list_len < LIST_CAP) begin
          for (i = list_len; i > r.pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[r.pos] = r.value;
          list_len++;
          res.okay = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (r.pos < list_len) begin
          list_len--;
          for (i = r.pos; i < list_len; i++) list_mem[i] = list_mem[i+1];
          res.okay = 1'b1;
        end
      end
      OP_READ: begin
        if (r.pos < list_len) begin
          res.rd_value = list_mem[r.pos];
          res.okay = 1'b1;
        end
      end
      default: begin
        list_len = 0;
        res.okay = 1'b1;
      end
    endcase
    res.len = list_len[LEN_W-1:0];
    res.full_flag = (list_len == LIST_CAP);
    n_op[r.op]++;
    if (res.okay) n_ok++;
    if (res.full_flag) n_full++;
    result_q.push_back(res);
  endtask

  // request generation; gen_len tracks the length only to shape positions
  task automatic add_req(input op_t op, input int pos, input logic [DATA_W-1:0] value);
    list_req_t r;
    r.op = op;
    r.pos = pos[POS_W-1:0];
    r.value = value;
    req_q.push_back(r);
    n_gen++;
    case (op)
      OP_INSERT: if (pos <= gen_len && gen_len < LIST_CAP) gen_len++;
      OP_REMOVE: if (pos < gen_len) gen_len--;
      OP_CLEAR:  gen_len = 0;
      default: ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_pos_below(input int n);
    if (n == 0 || $urandom_range(0, 9) == 0) return n;
    return $urandom_range(0, n - 1);
  endfunction

  // fill to capacity, hit the full list, read back, then drain part or all
  task automatic fill_and_drain();
    int n;
    while (gen_len < LIST_CAP) add_req(OP_INSERT, $urandom_range(0, gen_len), pick_value());
    repeat ($urandom_range(1, 2)) add_req(OP_INSERT, $urandom_range(0, LIST_CAP), pick_value());
    repeat ($urandom_range(2, 6)) add_req(OP_READ, $urandom_range(0, LIST_CAP - 1), $urandom);
    n = $urandom_range(1, LIST_CAP);
    repeat (n) if (gen_len > 0) add_req(OP_REMOVE, $urandom_range(0, gen_len - 1), $urandom);
  endtask

  // sender: bursts of requests separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) apply_req(cur_req);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          s_tdata <= {3'b000, cur_req.value, cur_req.pos};
          s_tuser <= cur_req.op;
          s_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: ready pattern switches between randomly chosen modes
  always @(posedge clk) begin
    cyc++;
    if (rst) begin
      m_tready <= 1'b0;
      rx_left = 0;
      rx_mode = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(10, 60);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= cyc[2];
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (result_q.size() == 0) begin
        $error("result with no request outstanding: m_tdata=%h", m_tdata);
        n_errors++;
      end else begin
        want_r = result_q.pop_front();
        n_results++;
        if (m_tdata[0] !== want_r.okay) begin
          $error("ok: expected %0d, got %0d", want_r.okay, m_tdata[0]);
          n_errors++;
        end
        if (m_tdata[32:1] !== want_r.rd_value) begin
          $error("read_value: expected %h, got %h", want_r.rd_value, m_tdata[32:1]);
          n_errors++;
        end
        if (m_tdata[37:33] !== want_r.len) begin
          $error("length: expected %0d, got %0d", want_r.len, m_tdata[37:33]);
          n_errors++;
        end
        if (m_tdata[38] !== want_r.full_flag) begin
          $error("full_res: expected %0d, got %0d", want_r.full_flag, m_tdata[38]);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int k;
    // directed: empty list, extremes, middle insert, bad positions, clear
    add_req(OP_READ, 0, 0);
    add_req(OP_REMOVE, 0, 0);
    add_req(OP_INSERT, 1, 32'h1234_5678);
    add_req(OP_INSERT, 0, 32'h8000_0000);
    add_req(OP_INSERT, 1, 32'h7fff_ffff);
    add_req(OP_INSERT, 0, 32'hffff_ffff);
    add_req(OP_INSERT, 1, 32'h0);
    for (k = 0; k < 4; k++) add_req(OP_READ, k, 32'hdead_beef);
    add_req(OP_READ, 4, 0);
    add_req(OP_READ, 31, 0);
    add_req(OP_REMOVE, 31, 0);
    add_req(OP_INSERT, 31, 32'h5555_aaaa);
    add_req(OP_REMOVE, 0, 0);
    add_req(OP_REMOVE, 2, 0);
    add_req(OP_READ, 1, 0);
    add_req(OP_CLEAR, 0, $urandom);
    add_req(OP_CLEAR, 31, $urandom);
    add_req(OP_READ, 0, 0);
    fill_and_drain();

    while (n_gen < RAND_ITEMS) begin
      k = $urandom_range(0, 99);
      if (k < 10) begin
        fill_and_drain();
      end else if (k < 18) begin
        add_req(op_t'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom);
      end else begin
        k = $urandom_range(0, 99);
        if (k < 40)
          add_req(OP_INSERT, ($urandom_range(0, 9) == 0) ? gen_len + 1 :
                  $urandom_range(0, gen_len), pick_value());
        else if (k < 65)
          add_req(OP_REMOVE, pick_pos_below(gen_len), $urandom);
        else if (k < 97)
          add_req(OP_READ, pick_pos_below(gen_len), $urandom);
        else
          add_req(OP_CLEAR, $urandom_range(0, 31), $urandom);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (req_q.size() != 0 || s_tvalid || result_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    $display("%0d requests (insert %0d, remove %0d, read %0d, clear %0d), %0d results checked",
             n_gen, n_op[OP_INSERT], n_op[OP_REMOVE], n_op[OP_READ], n_op[OP_CLEAR], n_results);
    $display("%0d succeeded, %0d left the list full, %0d mismatches", n_ok, n_full, n_errors);
    if (n_errors == 0 && result_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
